// ===== hw/rtl/rrls_pkg.sv =====
// Shared types and constants for the request/reply link sequencer.
// Holds item structs, action and event codes, register indexes and reset values.
// No dependencies.
package rrls_pkg;

  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned ADDR_W     = 8;
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIMER_W-1:0] REPLY_TIMEOUT_RST = 16'd2000;
  localparam logic [TIMER_W-1:0] STALE_TIMEOUT_RST = REPLY_TIMEOUT_RST + 16'd500;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_TIMEOUT = 1'd1;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_PROC  = 2'd1,
    ACT_SEND  = 2'd2,
    ACT_FRAME = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    EV_NONE          = 4'd0,
    EV_PENDING       = 4'd1,
    EV_INVALID_STATE = 4'd2,
    EV_PROTOCOL_RST  = 4'd3,
    EV_NOTIFIED      = 4'd4,
    EV_REPLY_SENT    = 4'd5,
    EV_REPLY_RIGHT   = 4'd6,
    EV_REPLY_WRONG   = 4'd7,
    EV_REPLY_TIMEOUT = 4'd8,
    EV_NOT_NEEDED    = 4'd9,
    EV_IGNORED       = 4'd10
  } event_t;

  typedef struct packed {
    action_t             action;
    logic                frame_is_request;
    logic                frame_is_reply;
    logic                reply_wanted_by_peer;
    logic                reply_is_right;
    logic                requires_reply;
    logic [ADDR_W-1:0]   peer_address;
    logic [DATA_W-1:0]   payload;
    logic [DATA_W-1:0]   app_reply_value;
  } in_item_t;

  typedef struct packed {
    event_t              event_code;
    logic [ADDR_W-1:0]   out_address;
    logic [DATA_W-1:0]   out_payload;
    logic                out_requires_reply;
    logic [2:0]          state_now;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_stage_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_stage_t;

endpackage

// ===== hw/rtl/rrls_in_if.sv =====
// Input channel of the link sequencer: valid/ready plus the item fields.
// Depends on rrls_pkg for field widths.
interface rrls_in_if
  import rrls_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic                frame_is_request;
  logic                frame_is_reply;
  logic                reply_wanted_by_peer;
  logic                reply_is_right;
  logic                requires_reply;
  logic [ADDR_W-1:0]   peer_address;
  logic [DATA_W-1:0]   payload;
  logic [DATA_W-1:0]   app_reply_value;

  modport source (
    output valid, action, frame_is_request, frame_is_reply, reply_wanted_by_peer,
           reply_is_right, requires_reply, peer_address, payload, app_reply_value,
    input  ready
  );

  modport sink (
    input  valid, action, frame_is_request, frame_is_reply, reply_wanted_by_peer,
           reply_is_right, requires_reply, peer_address, payload, app_reply_value,
    output ready
  );
endinterface

// ===== hw/rtl/rrls_out_if.sv =====
// Result channel of the link sequencer: valid/ready plus the result fields.
// Depends on rrls_pkg for field widths.
interface rrls_out_if
  import rrls_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [3:0]          event_code;
  logic [ADDR_W-1:0]   out_address;
  logic [DATA_W-1:0]   out_payload;
  logic                out_requires_reply;
  logic [2:0]          state_now;

  modport source (
    output valid, event_code, out_address, out_payload, out_requires_reply, state_now,
    input  ready
  );

  modport sink (
    input  valid, event_code, out_address, out_payload, out_requires_reply, state_now,
    output ready
  );
endinterface

// ===== hw/rtl/rrls_in_reg.sv =====
// Input register stage: captures one item from the input channel.
// Depends on rrls_pkg and rrls_in_if.
module rrls_in_reg
  import rrls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rrls_in_if.sink    in_ch,
  input  logic       take,
  output in_stage_t  stage
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     accept;

  // Free when empty or when the held item moves on this cycle
  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.action               <= action_t'(in_ch.action);
      item_r.frame_is_request     <= in_ch.frame_is_request;
      item_r.frame_is_reply       <= in_ch.frame_is_reply;
      item_r.reply_wanted_by_peer <= in_ch.reply_wanted_by_peer;
      item_r.reply_is_right       <= in_ch.reply_is_right;
      item_r.requires_reply       <= in_ch.requires_reply;
      item_r.peer_address         <= in_ch.peer_address;
      item_r.payload              <= in_ch.payload;
      item_r.app_reply_value      <= in_ch.app_reply_value;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// ===== hw/rtl/rrls_out_reg.sv =====
// Result register stage: holds one result until the sink takes it.
// Depends on rrls_pkg and rrls_out_if.
module rrls_out_reg
  import rrls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  res_stage_t  res,
  output logic        out_free,
  rrls_out_if.source  out_ch
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      item_r <= res.item;
    end
  end

  assign out_ch.valid              = valid_r;
  assign out_ch.event_code         = item_r.event_code;
  assign out_ch.out_address        = item_r.out_address;
  assign out_ch.out_payload        = item_r.out_payload;
  assign out_ch.out_requires_reply = item_r.out_requires_reply;
  assign out_ch.state_now          = item_r.state_now;

endmodule

// ===== hw/rtl/rrls_core.sv =====
// Sequencer core: state, timers, held frame data, timeout registers.
// Next state and result are worked out in one pass from the input register.
// Depends on rrls_pkg.
module rrls_core
  import rrls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_stage_t             stage,
  input  logic                  out_free,
  output logic                  take,
  output res_stage_t            res
);

  typedef enum logic [2:0] {
    ST_INITIAL      = 3'd0,
    ST_WAIT_REQUEST = 3'd1,
    ST_WAIT_REPLY   = 3'd2,
    ST_GOT_REQUEST  = 3'd3,
    ST_GOT_REPLY    = 3'd4,
    ST_SENT_REQUEST = 3'd5,
    ST_SENT_REPLY   = 3'd6
  } state_t;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  state_t              link_state_r, link_state_nxt, cur_state;
  logic [TIMER_W-1:0]  state_age_r, state_age_nxt;
  logic [TIMER_W-1:0]  reply_wait_age_r, reply_wait_age_nxt;
  logic                expect_reply_r, expect_reply_nxt;
  logic [ADDR_W-1:0]   held_address_r, held_address_nxt;
  logic [DATA_W-1:0]   held_payload_r, held_payload_nxt;
  logic                held_wants_reply_r, held_wants_reply_nxt;
  logic                held_reply_right_r, held_reply_right_nxt;
  logic [TIMER_W-1:0]  reply_to_r, stale_to_r;
  logic                moved;
  in_item_t            it;
  out_item_t           o;

  assign it   = stage.item;
  assign take = stage.valid && out_free;

  always_comb begin
    link_state_nxt       = link_state_r;
    state_age_nxt        = state_age_r;
    reply_wait_age_nxt   = reply_wait_age_r;
    expect_reply_nxt     = expect_reply_r;
    held_address_nxt     = held_address_r;
    held_payload_nxt     = held_payload_r;
    held_wants_reply_nxt = held_wants_reply_r;
    held_reply_right_nxt = held_reply_right_r;
    cur_state            = link_state_r;
    moved                = 1'b0;
    o                    = '0;
    o.event_code         = EV_NONE;

    unique case (it.action)
      ACT_TICK: begin
        if (state_age_r != TIMER_MAX) state_age_nxt = state_age_r + 1'b1;
        if (reply_wait_age_r != TIMER_MAX) reply_wait_age_nxt = reply_wait_age_r + 1'b1;
      end
      ACT_PROC: begin
        // Stale state forces initial first, then initial is handled below
        if (state_age_r > stale_to_r) begin
          cur_state      = ST_INITIAL;
          link_state_nxt = ST_INITIAL;
          moved          = 1'b1;
        end
        unique case (cur_state)
          ST_INITIAL: begin
            o.event_code   = EV_PROTOCOL_RST;
            link_state_nxt = ST_WAIT_REQUEST;
            moved          = 1'b1;
          end
          ST_WAIT_REPLY: begin
            if (reply_wait_age_r > reply_to_r) begin
              o.event_code   = EV_REPLY_TIMEOUT;
              link_state_nxt = ST_INITIAL;
              moved          = 1'b1;
            end
          end
          ST_GOT_REQUEST: begin
            o.out_address = held_address_r;
            moved         = 1'b1;
            if (!held_wants_reply_r) begin
              o.event_code   = EV_NOTIFIED;
              o.out_payload  = held_payload_r;
              link_state_nxt = ST_INITIAL;
            end else begin
              o.event_code   = EV_REPLY_SENT;
              o.out_payload  = it.app_reply_value;
              link_state_nxt = ST_SENT_REPLY;
            end
          end
          ST_GOT_REPLY: begin
            if (held_reply_right_r) begin
              o.event_code  = EV_REPLY_RIGHT;
              o.out_payload = held_payload_r;
            end else begin
              o.event_code  = EV_REPLY_WRONG;
            end
            link_state_nxt = ST_INITIAL;
            moved          = 1'b1;
          end
          ST_SENT_REQUEST: begin
            moved = 1'b1;
            if (!expect_reply_r) begin
              o.event_code   = EV_NOT_NEEDED;
              link_state_nxt = ST_INITIAL;
            end else begin
              link_state_nxt     = ST_WAIT_REPLY;
              reply_wait_age_nxt = '0;
            end
          end
          ST_SENT_REPLY: begin
            link_state_nxt = ST_INITIAL;
            moved          = 1'b1;
          end
          default: begin
            // wait request, and the unused code: hold
          end
        endcase
      end
      ACT_SEND: begin
        if (link_state_r != ST_WAIT_REQUEST) begin
          o.event_code = EV_INVALID_STATE;
        end else begin
          o.event_code         = EV_PENDING;
          o.out_address        = it.peer_address;
          o.out_payload        = it.payload;
          o.out_requires_reply = it.requires_reply;
          expect_reply_nxt     = it.requires_reply;
          link_state_nxt       = ST_SENT_REQUEST;
          moved                = 1'b1;
        end
      end
      ACT_FRAME: begin
        if (link_state_r == ST_WAIT_REQUEST && it.frame_is_request) begin
          held_address_nxt     = it.peer_address;
          held_payload_nxt     = it.payload;
          held_wants_reply_nxt = it.reply_wanted_by_peer;
          link_state_nxt       = ST_GOT_REQUEST;
          moved                = 1'b1;
        end else if (link_state_r == ST_WAIT_REPLY && it.frame_is_reply) begin
          held_address_nxt     = it.peer_address;
          held_payload_nxt     = it.payload;
          held_reply_right_nxt = it.reply_is_right;
          link_state_nxt       = ST_GOT_REPLY;
          moved                = 1'b1;
        end else begin
          o.event_code = EV_IGNORED;
        end
      end
      default: begin
      end
    endcase

    if (moved) state_age_nxt = '0;
    o.state_now = link_state_nxt;
  end

  assign res.valid = take;
  assign res.item  = o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_state_r       <= ST_INITIAL;
      state_age_r        <= '0;
      reply_wait_age_r   <= '0;
      expect_reply_r     <= 1'b0;
      held_address_r     <= '0;
      held_payload_r     <= '0;
      held_wants_reply_r <= 1'b0;
      held_reply_right_r <= 1'b0;
    end else if (take) begin
      link_state_r       <= link_state_nxt;
      state_age_r        <= state_age_nxt;
      reply_wait_age_r   <= reply_wait_age_nxt;
      expect_reply_r     <= expect_reply_nxt;
      held_address_r     <= held_address_nxt;
      held_payload_r     <= held_payload_nxt;
      held_wants_reply_r <= held_wants_reply_nxt;
      held_reply_right_r <= held_reply_right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_to_r <= REPLY_TIMEOUT_RST;
      stale_to_r <= STALE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPLY_TIMEOUT: reply_to_r <= cfg_data;
        CFG_STALE_TIMEOUT: stale_to_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(link_state_r) && $stable(state_age_r))
    else $error("sequencer state moved without an item");

  a_state_reported: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> link_state_r == $past(res.item.state_now))
    else $error("reported state differs from stored state");

  a_send_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    take && it.action == ACT_SEND && link_state_r == ST_WAIT_REQUEST
    |=> link_state_r == ST_SENT_REQUEST && state_age_r == '0)
    else $error("send in wait request did not reach sent request");

  a_wait_entry: assert property (@(posedge clk) disable iff (!rst_n)
    take && it.action == ACT_PROC && link_state_r == ST_SENT_REQUEST && expect_reply_r
    && !(state_age_r > stale_to_r) |=> link_state_r == ST_WAIT_REPLY && reply_wait_age_r == '0)
    else $error("reply wait timer not cleared on entering wait reply");
`endif

endmodule

// ===== hw/rtl/request_reply_link_sequencer.sv =====
// Top level of the request/reply link sequencer.
// Depends on rrls_pkg, rrls_in_if, rrls_out_if, rrls_in_reg, rrls_core, rrls_out_reg.
//
//   channel  | direction | handshake      | carries
//   ---------+-----------+----------------+------------------------------------------
//   in_ch    | in        | valid / ready  | action, frame flags, address, payload,
//            |           |                | application reply value
//   out_ch   | out       | valid / ready  | event code, address, payload,
//            |           |                | requires-reply echo, state after the item
//   cfg_*    | in        | write enable   | index 0 reply timeout, 1 stale timeout
//
// One item per clock sustained while out_ch.ready stays high: an item is captured
// in the input register, is resolved by the core's next-state logic and lands in
// the result register. Reset (rst_n low, synchronous) empties both registers,
// clears state and timers and loads the default timeouts; no clearing pass is
// needed. A stalled result holds in the result register while the input register
// still takes one more item; only then is in_ch.ready dropped.
module request_reply_link_sequencer
  import rrls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  rrls_in_if.sink               in_ch,
  rrls_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  in_stage_t  stage;
  res_stage_t res;
  logic       take;
  logic       out_free;

  // Capture the arriving item
  rrls_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  // Advance the sequencer when the result register has room
  rrls_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .out_free  (out_free),
    .take      (take),
    .res       (res)
  );

  // Hold the result until the sink takes it
  rrls_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the request/reply link sequencer.
// Drives rrls_in_if items, checks rrls_out_if results against an in-bench model.
// Depends on rrls_pkg, rrls_in_if, rrls_out_if and request_reply_link_sequencer.
`timescale 1ns / 100ps

module tb;
  import rrls_pkg::*;

  // Link states as the block reports them in state_now
  typedef enum logic [2:0] {
    LS_INITIAL      = 3'd0,
    LS_WAIT_REQUEST = 3'd1,
    LS_WAIT_REPLY   = 3'd2,
    LS_GOT_REQUEST  = 3'd3,
    LS_GOT_REPLY    = 3'd4,
    LS_SENT_REQUEST = 3'd5,
    LS_SENT_REPLY   = 3'd6
  } link_state_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rrls_in_if  in_ch ();
  rrls_out_if out_ch ();

  request_reply_link_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the sequencer: timeouts, state, timers and the held frame
  logic [TIMER_W-1:0] tmo_reply = REPLY_TIMEOUT_RST;
  logic [TIMER_W-1:0] tmo_stale = STALE_TIMEOUT_RST;
  link_state_t        link_now  = LS_INITIAL;
  logic [TIMER_W-1:0] age_state = '0;
  logic [TIMER_W-1:0] age_wait  = '0;
  logic               want_reply_back = 1'b0;
  logic [ADDR_W-1:0]  held_addr  = '0;
  logic [DATA_W-1:0]  held_pay   = '0;
  logic               held_wants = 1'b0;
  logic               held_right = 1'b0;

  // Results still owed by the block, oldest first
  out_item_t events_due[$];

  int unsigned mismatches = 0;
  int unsigned gap_pct    = 0;   // chance of a sender pause before an item
  int unsigned stall_pct  = 0;   // chance of a receiver stall burst starting
  int unsigned stall_left = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("tb: mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Any change of state, even to the same one, restarts the state timer
  function automatic void enter(input link_state_t s);
    link_now  = s;
    age_state = '0;
  endfunction

  // Advance the shadow sequencer by one accepted item and give its result
  task automatic advance_link(input in_item_t it, output out_item_t r);
    r = '0;
    r.event_code = EV_NONE;
    case (it.action)
      ACT_TICK: begin
        age_state = sat_inc(age_state);
        age_wait  = sat_inc(age_wait);
      end
      ACT_PROC: begin
        // stale check comes first; the initial state is then handled at once
        if (age_state > tmo_stale) enter(LS_INITIAL);
        case (link_now)
          LS_INITIAL: begin
            r.event_code = EV_PROTOCOL_RST;
            enter(LS_WAIT_REQUEST);
          end
          LS_WAIT_REPLY: begin
            if (age_wait > tmo_reply) begin
              r.event_code = EV_REPLY_TIMEOUT;
              enter(LS_INITIAL);
            end
          end
          LS_GOT_REQUEST: begin
            r.out_address = held_addr;
            if (!held_wants) begin
              r.event_code  = EV_NOTIFIED;
              r.out_payload = held_pay;
              enter(LS_INITIAL);
            end else begin
              r.event_code  = EV_REPLY_SENT;
              r.out_payload = it.app_reply_value;
              enter(LS_SENT_REPLY);
            end
          end
          LS_GOT_REPLY: begin
            if (held_right) begin
              r.event_code  = EV_REPLY_RIGHT;
              r.out_payload = held_pay;
            end else begin
              r.event_code = EV_REPLY_WRONG;
            end
            enter(LS_INITIAL);
          end
          LS_SENT_REQUEST: begin
            if (!want_reply_back) begin
              r.event_code = EV_NOT_NEEDED;
              enter(LS_INITIAL);
            end else begin
              enter(LS_WAIT_REPLY);
              age_wait = '0;
            end
          end
          LS_SENT_REPLY: enter(LS_INITIAL);
          default: ;
        endcase
      end
      ACT_SEND: begin
        if (link_now != LS_WAIT_REQUEST) begin
          r.event_code = EV_INVALID_STATE;
        end else begin
          r.event_code         = EV_PENDING;
          r.out_address        = it.peer_address;
          r.out_payload        = it.payload;
          r.out_requires_reply = it.requires_reply;
          want_reply_back      = it.requires_reply;
          enter(LS_SENT_REQUEST);
        end
      end
      default: begin
        // a frame flagged both ways counts as a request in wait request
        if (link_now == LS_WAIT_REQUEST && it.frame_is_request) begin
          held_addr  = it.peer_address;
          held_pay   = it.payload;
          held_wants = it.reply_wanted_by_peer;
          enter(LS_GOT_REQUEST);
        end else if (link_now == LS_WAIT_REPLY && it.frame_is_reply) begin
          held_addr  = it.peer_address;
          held_pay   = it.payload;
          held_right = it.reply_is_right;
          enter(LS_GOT_REPLY);
        end else begin
          r.event_code = EV_IGNORED;
        end
      end
    endcase
    r.state_now = link_now;
  endtask

  // Drive one item at the falling edge, hold it until accepted, then predict
  task automatic send_item(input in_item_t it);
    int unsigned gap_len;
    out_item_t   r;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap_len = $urandom_range(1, 19);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap_len - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid                = 1'b1;
    in_ch.action               = it.action;
    in_ch.frame_is_request     = it.frame_is_request;
    in_ch.frame_is_reply       = it.frame_is_reply;
    in_ch.reply_wanted_by_peer = it.reply_wanted_by_peer;
    in_ch.reply_is_right       = it.reply_is_right;
    in_ch.requires_reply       = it.requires_reply;
    in_ch.peer_address         = it.peer_address;
    in_ch.payload              = it.payload;
    in_ch.app_reply_value      = it.app_reply_value;
    do @(posedge clk); while (!in_ch.ready);
    advance_link(it, r);
    events_due.push_back(r);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    it.action               = action_t'($urandom_range(0, 3));
    it.frame_is_request     = 1'($urandom_range(0, 1));
    it.frame_is_reply       = 1'($urandom_range(0, 1));
    it.reply_wanted_by_peer = 1'($urandom_range(0, 1));
    it.reply_is_right       = 1'($urandom_range(0, 1));
    it.requires_reply       = 1'($urandom_range(0, 1));
    it.peer_address         = ADDR_W'($urandom_range(0, 255));
    it.payload              = DATA_W'($urandom_range(0, 65535));
    it.app_reply_value      = DATA_W'($urandom_range(0, 65535));
    return it;
  endfunction

  task automatic send_act(input action_t a);
    in_item_t it;
    it = random_item();
    it.action = a;
    send_item(it);
  endtask

  task automatic send_frame(input logic is_req, input logic is_rep, input logic wants,
                            input logic right, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] pay);
    in_item_t it;
    it = random_item();
    it.action               = ACT_FRAME;
    it.frame_is_request     = is_req;
    it.frame_is_reply       = is_rep;
    it.reply_wanted_by_peer = wants;
    it.reply_is_right       = right;
    it.peer_address         = addr;
    it.payload              = pay;
    send_item(it);
  endtask

  task automatic send_request(input logic rr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] pay);
    in_item_t it;
    it = random_item();
    it.action         = ACT_SEND;
    it.requires_reply = rr;
    it.peer_address   = addr;
    it.payload        = pay;
    send_item(it);
  endtask

  // Drop valid and wait until every owed result is back
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIMER_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_REPLY_TIMEOUT) tmo_reply = val;
    else tmo_stale = val;
  endtask

  // Timeouts only change while the block is idle
  task automatic set_timeouts(input logic [TIMER_W-1:0] reply, input logic [TIMER_W-1:0] stale);
    settle();
    write_reg(CFG_REPLY_TIMEOUT, reply);
    write_reg(CFG_STALE_TIMEOUT, stale);
  endtask

  // Steer the link into wait request from wherever it stands
  task automatic go_wait_request();
    while (link_now != LS_WAIT_REQUEST) begin
      if (link_now == LS_WAIT_REPLY) send_frame(1'b0, 1'b1, 1'b0, 1'b1, 8'h5A, 16'hA5A5);
      else send_act(ACT_PROC);
    end
  endtask

  task automatic go_wait_reply();
    go_wait_request();
    send_request(1'b1, 8'h3C, 16'h0F0F);
    send_act(ACT_PROC);
  endtask

  // Well-formed traffic for the current state most of the time, noise otherwise
  function automatic in_item_t pick_item();
    in_item_t    it;
    int unsigned r;
    it = random_item();
    r  = $urandom_range(0, 99);
    if (r < 12) begin
      it.action = ACT_TICK;
      return it;
    end
    if (r < 20) return it;
    case (link_now)
      LS_WAIT_REQUEST: begin
        if (r < 60) begin
          it.action = ACT_SEND;
        end else begin
          it.action           = ACT_FRAME;
          it.frame_is_request = 1'b1;
        end
      end
      LS_WAIT_REPLY: begin
        if (r < 45) begin
          it.action = ACT_TICK;
        end else if (r < 55) begin
          it.action = ACT_PROC;
        end else begin
          it.action         = ACT_FRAME;
          it.frame_is_reply = 1'b1;
        end
      end
      default: it.action = ACT_PROC;
    endcase
    return it;
  endfunction

  // Walk every event but the reply timeout, with extreme addresses and payloads
  task automatic test_basic_flow();
    gap_pct   = 30;
    stall_pct = 30;
    send_act(ACT_SEND);                                      // rejected in initial
    send_frame(1'b1, 1'b0, 1'b1, 1'b1, 8'hFF, 16'hFFFF);     // ignored in initial
    send_act(ACT_TICK);
    send_act(ACT_PROC);                                      // protocol reset
    send_frame(1'b1, 1'b1, 1'b0, 1'b0, 8'hFF, 16'hFFFF);     // both flags: a request
    send_act(ACT_PROC);                                      // notified, no reply
    send_act(ACT_PROC);
    send_frame(1'b0, 1'b1, 1'b1, 1'b1, 8'h12, 16'h3456);     // reply while idle: ignored
    send_frame(1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 16'h0000);
    send_act(ACT_SEND);                                      // rejected in got request
    send_act(ACT_PROC);                                      // reply frame sent
    send_act(ACT_PROC);                                      // sent reply back to initial
    send_act(ACT_PROC);
    send_request(1'b0, 8'hAA, 16'h1234);
    send_act(ACT_PROC);                                      // reply not needed
    send_act(ACT_PROC);
    send_request(1'b1, 8'h55, 16'hFFFF);
    send_act(ACT_PROC);                                      // into wait reply
    send_act(ACT_PROC);                                      // quiet wait
    send_frame(1'b1, 1'b0, 1'b1, 1'b1, 8'h81, 16'h8001);     // request while waiting: ignored
    send_frame(1'b0, 1'b1, 1'b0, 1'b1, 8'h7E, 16'hBEEF);
    send_act(ACT_PROC);                                      // reply right
    go_wait_reply();
    send_frame(1'b1, 1'b1, 1'b1, 1'b0, 8'h01, 16'h0001);
    send_act(ACT_PROC);                                      // reply wrong
  endtask

  // Reply timer cleared on entry to wait reply, fires strictly above the limit
  task automatic test_reply_timeout();
    set_timeouts(16'd0, 16'hFFFF);
    go_wait_request();
    send_act(ACT_TICK);
    send_act(ACT_TICK);
    go_wait_reply();
    send_act(ACT_PROC);                                      // age 0: no timeout yet
    send_act(ACT_TICK);
    send_act(ACT_PROC);                                      // timeout
  endtask

  // Stale timer forces initial, handled in the same processing cycle
  task automatic test_stale_timeout();
    set_timeouts(16'hFFFF, 16'd0);
    go_wait_request();
    send_act(ACT_PROC);
    send_act(ACT_TICK);
    send_act(ACT_PROC);                                      // stale, then protocol reset
    send_frame(1'b1, 1'b0, 1'b0, 1'b0, 8'hC3, 16'h00FF);
    send_act(ACT_TICK);
    send_act(ACT_PROC);                                      // stale beats the notify
  endtask

  // A limit of all ones stays quiet; a lower limit then fires on the same wait
  task automatic test_timeout_disabled();
    set_timeouts(16'hFFFF, 16'hFFFF);
    gap_pct   = 0;
    stall_pct = 0;
    go_wait_reply();
    repeat (40) send_act(ACT_TICK);
    send_act(ACT_PROC);                                      // quiet wait
    set_timeouts(16'd39, 16'hFFFF);
    send_act(ACT_PROC);                                      // timeout
  endtask

  task automatic test_random_phase(input int unsigned n, input logic [TIMER_W-1:0] reply,
                                   input logic [TIMER_W-1:0] stale,
                                   input int unsigned gaps, input int unsigned stalls);
    set_timeouts(reply, stale);
    gap_pct   = gaps;
    stall_pct = stalls;
    repeat (n) send_item(pick_item());
  endtask

  // Receiver side: ready drops in bursts of random length
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ch.ready = 1'b0;
      stall_left   = $urandom_range(1, 19) - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Compare each accepted result with the oldest one owed
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (events_due.size() == 0) begin
        report_mismatch("result arrived with nothing owed");
      end else begin
        want = events_due.pop_front();
        if (out_ch.event_code !== want.event_code || out_ch.out_address !== want.out_address ||
            out_ch.out_payload !== want.out_payload ||
            out_ch.out_requires_reply !== want.out_requires_reply ||
            out_ch.state_now !== want.state_now)
          report_mismatch($sformatf({"got ev=%0d addr=%02h pay=%04h rr=%0b st=%0d, ",
                                     "want ev=%0d addr=%02h pay=%04h rr=%0b st=%0d"},
            out_ch.event_code, out_ch.out_address, out_ch.out_payload,
            out_ch.out_requires_reply, out_ch.state_now, want.event_code, want.out_address,
            want.out_payload, want.out_requires_reply, want.state_now));
      end
    end
  end

  initial begin
    // Hold every input at a known value and keep the block in reset
    rst_n                      = 1'b0;
    cfg_we                     = 1'b0;
    cfg_index                  = CFG_REPLY_TIMEOUT;
    cfg_data                   = '0;
    in_ch.valid                = 1'b0;
    in_ch.action               = ACT_TICK;
    in_ch.frame_is_request     = 1'b0;
    in_ch.frame_is_reply       = 1'b0;
    in_ch.reply_wanted_by_peer = 1'b0;
    in_ch.reply_is_right       = 1'b0;
    in_ch.requires_reply       = 1'b0;
    in_ch.peer_address         = '0;
    in_ch.payload              = '0;
    in_ch.app_reply_value      = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_basic_flow();
    test_reply_timeout();
    test_stale_timeout();
    test_timeout_disabled();
    test_random_phase(300, 16'd5, 16'd12, 25, 25);
    test_random_phase(300, 16'd0, 16'd3, 10, 40);
    test_random_phase(300, 16'd2, 16'd0, 40, 0);
    test_random_phase(300, 16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)), 0, 0);
    test_random_phase(300, REPLY_TIMEOUT_RST, STALE_TIMEOUT_RST, 20, 20);
    // last stretch runs flat out: no pauses on either side
    test_random_phase(350, 16'd1, 16'd6, 0, 0);
    settle();

    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #12_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rrls_pkg.sv
hw/rtl/rrls_in_if.sv
hw/rtl/rrls_out_if.sv
hw/rtl/rrls_in_reg.sv
hw/rtl/rrls_out_reg.sv
hw/rtl/rrls_core.sv
hw/rtl/request_reply_link_sequencer.sv
tb/tb.sv
